// ----- rtl/priority_task_scheduler_top_macros.svh -----
// Assertion helpers shared by the scheduler RTL.
`ifndef PRIORITY_TASK_SCHEDULER_TOP_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define PTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define PTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pts_pkg.sv -----
package pts_pkg;

  // Internal widths cover the full parameter range (up to 64 tasks and priorities).
  localparam int TID_W   = 6;
  localparam int PRI_W   = 6;
  localparam int RANK_W  = 6;
  localparam int WL_W    = 7;
  localparam int CNT_W   = 32;
  localparam int SLICE_W = 16;

  localparam logic [7:0] LOCK_MAX = 8'd255;

  localparam logic [2:0] K_READY   = 3'd0;
  localparam logic [2:0] K_UNREADY = 3'd1;
  localparam logic [2:0] K_DELAY   = 3'd2;
  localparam logic [2:0] K_TICK    = 3'd3;
  localparam logic [2:0] K_LOCK    = 3'd4;
  localparam logic [2:0] K_UNLOCK  = 3'd5;
  localparam logic [2:0] K_SCHED   = 3'd6;
  localparam logic [2:0] K_WAKE    = 3'd7;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic               rem_en;
    logic [TID_W-1:0]   rem_id;
    logic [PRI_W-1:0]   rem_prio;
    logic [RANK_W-1:0]  rem_rank;
    logic               ins_en;
    logic               ins_front;
    logic [TID_W-1:0]   ins_id;
    logic [PRI_W-1:0]   ins_prio;
    logic [RANK_W-1:0]  ins_rank;
    logic [SLICE_W-1:0] slice_load;
    logic               drem_en;
    logic [TID_W-1:0]   drem_id;
    logic [RANK_W-1:0]  drem_rank;
    logic               dapp_en;
    logic [TID_W-1:0]   dapp_id;
    logic [RANK_W-1:0]  dapp_rank;
    logic [CNT_W-1:0]   dapp_count;
    logic               dec_en;
    logic [TID_W-1:0]   dec_id;
    logic               sdec_en;
    logic [TID_W-1:0]   sdec_id;
    logic               q_by_rank;
    logic [TID_W-1:0]   q_id;
    logic [RANK_W-1:0]  q_rank;
    logic [PRI_W-1:0]   scan_prio;
  } cell_cmd_t;

  // State of the queried cell; zero from every other cell.
  typedef struct packed {
    logic               hit;
    logic [TID_W-1:0]   id;
    logic               ready;
    logic [PRI_W-1:0]   prio;
    logic [RANK_W-1:0]  rank;
    logic               delayed;
    logic [RANK_W-1:0]  drank;
    logic [CNT_W-1:0]   wcount;
    logic [SLICE_W-1:0] slice;
  } cell_view_t;

  // Token that walks the chain: best queue head so far and a priority count.
  typedef struct packed {
    logic             found;
    logic [PRI_W-1:0] prio;
    logic [TID_W-1:0] id;
    logic [WL_W-1:0]  count;
  } scan_t;

endpackage

// ----- rtl/pts_cell.sv -----
module pts_cell import pts_pkg::*; #(
  parameter int CELL_ID = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  cell_cmd_t  cmd,
  input  scan_t      scan_in,
  output scan_t      scan_out,
  output cell_view_t view,
  output logic       is_ready
);

  localparam logic [TID_W-1:0] MY_ID = TID_W'(CELL_ID);

  logic               ready, ready_next;
  logic               delayed, delayed_next;
  logic [PRI_W-1:0]   prio, prio_next;
  logic [RANK_W-1:0]  rank, rank_next;
  logic [RANK_W-1:0]  drank, drank_next;
  logic [CNT_W-1:0]   wcount, wcount_next;
  logic [SLICE_W-1:0] slice, slice_next;
  scan_t              scan_q, scan_next;
  logic               rank_dn, rank_up, drank_dn, match;

  always_comb begin
    rank_dn  = cmd.rem_en && ready && (prio == cmd.rem_prio) && (rank > cmd.rem_rank);
    rank_up  = cmd.ins_en && cmd.ins_front && ready && (prio == cmd.ins_prio);
    drank_dn = cmd.drem_en && delayed && (drank > cmd.drem_rank);

    ready_next   = ready;
    prio_next    = prio;
    rank_next    = rank - RANK_W'(rank_dn) + RANK_W'(rank_up);
    slice_next   = slice;
    delayed_next = delayed;
    drank_next   = drank - RANK_W'(drank_dn);
    wcount_next  = wcount;

    if (cmd.ins_en && cmd.ins_id == MY_ID) begin
      ready_next = 1'b1;
      prio_next  = cmd.ins_prio;
      rank_next  = cmd.ins_front ? '0 : cmd.ins_rank;
      slice_next = cmd.slice_load;
    end else begin
      if (cmd.rem_en && cmd.rem_id == MY_ID) begin
        ready_next = 1'b0;
      end
      if (cmd.sdec_en && cmd.sdec_id == MY_ID) begin
        slice_next = slice - SLICE_W'(1);
      end
    end

    if (cmd.dapp_en && cmd.dapp_id == MY_ID) begin
      delayed_next = 1'b1;
      drank_next   = cmd.dapp_rank;
      wcount_next  = cmd.dapp_count;
    end else begin
      if (cmd.drem_en && cmd.drem_id == MY_ID) begin
        delayed_next = 1'b0;
      end
      if (cmd.dec_en && cmd.dec_id == MY_ID) begin
        wcount_next = wcount - CNT_W'(1);
      end
    end

    // Fold this cell into the passing token.
    scan_next = scan_in;
    if (ready && rank == '0 && (!scan_in.found || prio < scan_in.prio)) begin
      scan_next.found = 1'b1;
      scan_next.prio  = prio;
      scan_next.id    = MY_ID;
    end
    if (ready && prio == cmd.scan_prio) begin
      scan_next.count = scan_in.count + WL_W'(1);
    end

    match = cmd.q_by_rank ? (delayed && drank == cmd.q_rank) : (cmd.q_id == MY_ID);
    view  = '0;
    if (match) begin
      view.hit     = 1'b1;
      view.id      = MY_ID;
      view.ready   = ready;
      view.prio    = prio;
      view.rank    = rank;
      view.delayed = delayed;
      view.drank   = drank;
      view.wcount  = wcount;
      view.slice   = slice;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready   <= 1'b0;
      delayed <= 1'b0;
      scan_q  <= '0;
    end else begin
      ready   <= ready_next;
      delayed <= delayed_next;
      scan_q  <= scan_next;
    end
  end

  always_ff @(posedge clk) begin
    prio   <= prio_next;
    rank   <= rank_next;
    drank  <= drank_next;
    wcount <= wcount_next;
    slice  <= slice_next;
  end

  assign scan_out = scan_q;
  assign is_ready = ready;

endmodule

// ----- rtl/priority_task_scheduler_top.sv -----
// Priority task scheduler. Pulse start with a command while busy is low; the
// block raises busy, works the command, and shows one result on switch_now,
// next_task, any_ready and lock_depth, marked by a one-cycle done pulse.
// The receiver cannot stall: sample the result in the cycle done is high.
// Each task lives in one cell of a row of NUM_TASKS cells; a token steps one
// cell per cycle along the row to find the most urgent queue head, so every
// scheduling decision costs one full pass of the row. Ready, unready, delay,
// wake, lock and a non-final unlock are applied directly; schedule and the
// unlock that drops the lock to zero also pass the row once to decide; a tick
// walks the delay list one entry a cycle, then passes the row once to size
// the running task's queue and once to decide. Write slice_ticks through
// slice_ticks_we/slice_ticks_wdata only while idle; the block itself does not
// enforce this.
`include "priority_task_scheduler_top_macros.svh"

module priority_task_scheduler_top import pts_pkg::*; #(
  parameter int NUM_TASKS      = 32,
  parameter int NUM_PRIORITIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [4:0]  task_id,
  input  logic [4:0]  task_priority,
  input  logic [31:0] delay_ticks,
  input  logic        slice_ticks_we,
  input  logic [15:0] slice_ticks_wdata,
  output logic        done,
  output logic        switch_now,
  output logic [4:0]  next_task,
  output logic        any_ready,
  output logic [7:0]  lock_depth
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_APPLY = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_CNT   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam logic [WL_W-1:0] ROW_LEN = WL_W'(NUM_TASKS);

  logic [2:0]          state, state_next;
  logic [2:0]          kind_q;
  logic [4:0]          tid_q;
  logic [4:0]          prio_q;
  logic [31:0]         ticks_q;
  logic [7:0]          lock_count, lock_count_next;
  logic [4:0]          running_task, running_task_next;
  logic [WL_W-1:0]     wait_len, wait_len_next;
  logic [WL_W-1:0]     walk_n, walk_n_next;
  logic [WL_W-1:0]     walk_i, walk_i_next;
  logic [RANK_W-1:0]   walk_k, walk_k_next;
  logic [WL_W-1:0]     cnt, cnt_next;
  logic                sw_q, sw_next;
  logic [SLICE_W-1:0]  slice_ticks;

  cell_cmd_t           cmd;
  cell_view_t          views [NUM_TASKS];
  scan_t               chain [NUM_TASKS];
  logic [NUM_TASKS-1:0] ready_bits;
  cell_view_t          v;
  scan_t               res;
  logic                tid_ok, pri_ok;
  logic [TID_W-1:0]    tid6, run6;
  logic [SLICE_W-1:0]  slice_dec;

  // Row of task cells; the token enters empty at cell 0.
  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    pts_cell #(.CELL_ID(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .scan_in  ((i == 0) ? scan_t'('0) : chain[(i == 0) ? 0 : i - 1]),
      .scan_out (chain[i]),
      .view     (views[i]),
      .is_ready (ready_bits[i])
    );
  end

  // Only the queried cell drives its view; OR the row together.
  always_comb begin
    v = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      v = cell_view_t'(v | views[i]);
    end
  end

  assign res    = chain[NUM_TASKS-1];
  assign tid_ok = int'(tid_q) < NUM_TASKS;
  assign pri_ok = int'(prio_q) < NUM_PRIORITIES;
  assign tid6   = TID_W'(tid_q);
  assign run6   = TID_W'(running_task);
  assign slice_dec = v.slice - SLICE_W'(1);
  assign busy   = (state != S_IDLE);

  always_comb begin
    cmd               = '0;
    cmd.slice_load    = slice_ticks;
    cmd.q_by_rank     = (state == S_WALK);
    cmd.q_rank        = walk_k;
    cmd.q_id          = (state == S_CNT) ? run6 : tid6;
    cmd.scan_prio     = v.prio;
    state_next        = state;
    lock_count_next   = lock_count;
    running_task_next = running_task;
    wait_len_next     = wait_len;
    walk_n_next       = walk_n;
    walk_i_next       = walk_i;
    walk_k_next       = walk_k;
    cnt_next          = cnt;
    sw_next           = sw_q;

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_APPLY;
          sw_next    = 1'b0;
        end
      end

      S_APPLY: begin
        state_next = S_FIN;
        cnt_next   = '0;
        case (kind_q)
          K_READY: begin
            if (tid_ok && pri_ok) begin
              // Drop the task from its old queue, push it at the head of the new one.
              cmd.rem_en    = v.ready;
              cmd.rem_id    = tid6;
              cmd.rem_prio  = v.prio;
              cmd.rem_rank  = v.rank;
              cmd.ins_en    = 1'b1;
              cmd.ins_front = 1'b1;
              cmd.ins_id    = tid6;
              cmd.ins_prio  = PRI_W'(prio_q);
            end
          end
          K_UNREADY: begin
            if (tid_ok) begin
              cmd.rem_en   = v.ready;
              cmd.rem_id   = tid6;
              cmd.rem_prio = v.prio;
              cmd.rem_rank = v.rank;
            end
          end
          K_DELAY: begin
            if (tid_ok) begin
              cmd.drem_en    = v.delayed;
              cmd.drem_id    = tid6;
              cmd.drem_rank  = v.drank;
              cmd.dapp_en    = 1'b1;
              cmd.dapp_id    = tid6;
              cmd.dapp_count = ticks_q;
              cmd.dapp_rank  = RANK_W'(wait_len - WL_W'(v.delayed));
              wait_len_next  = wait_len - WL_W'(v.delayed) + WL_W'(1);
            end
          end
          K_WAKE: begin
            if (tid_ok) begin
              cmd.drem_en   = v.delayed;
              cmd.drem_id   = tid6;
              cmd.drem_rank = v.drank;
              wait_len_next = wait_len - WL_W'(v.delayed);
            end
          end
          K_TICK: begin
            state_next  = S_WALK;
            walk_n_next = wait_len;
            walk_i_next = '0;
            walk_k_next = '0;
          end
          K_LOCK: begin
            if (lock_count < LOCK_MAX) begin
              lock_count_next = lock_count + 8'd1;
            end
          end
          K_UNLOCK: begin
            if (lock_count != 8'd0) begin
              lock_count_next = lock_count - 8'd1;
              if (lock_count == 8'd1) begin
                state_next = S_SCAN;
              end
            end
          end
          K_SCHED: begin
            state_next = S_SCAN;
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end

      S_WALK: begin
        // One delay-list entry per cycle, in list order.
        if (walk_i == walk_n) begin
          state_next = S_CNT;
          cnt_next   = '0;
        end else begin
          walk_i_next = walk_i + WL_W'(1);
          cmd.dec_en  = 1'b1;
          cmd.dec_id  = v.id;
          if (v.wcount == CNT_W'(1)) begin
            // Expired: unlink it; the next entry slides into this position.
            cmd.drem_en   = 1'b1;
            cmd.drem_id   = v.id;
            cmd.drem_rank = walk_k;
            wait_len_next = wait_len - WL_W'(1);
            if (int'(v.prio) < NUM_PRIORITIES) begin
              cmd.rem_en    = v.ready;
              cmd.rem_id    = v.id;
              cmd.rem_prio  = v.prio;
              cmd.rem_rank  = v.rank;
              cmd.ins_en    = 1'b1;
              cmd.ins_front = 1'b1;
              cmd.ins_id    = v.id;
              cmd.ins_prio  = v.prio;
            end
          end else begin
            walk_k_next = walk_k + RANK_W'(1);
          end
        end
      end

      S_CNT: begin
        // Token pass sizes the running task's queue, then charge its slice.
        cnt_next = cnt + WL_W'(1);
        if (cnt == ROW_LEN) begin
          cnt_next   = '0;
          state_next = S_SCAN;
          if (slice_dec == '0 && v.ready) begin
            cmd.rem_en    = 1'b1;
            cmd.rem_id    = run6;
            cmd.rem_prio  = v.prio;
            cmd.rem_rank  = v.rank;
            cmd.ins_en    = 1'b1;
            cmd.ins_front = 1'b0;
            cmd.ins_id    = run6;
            cmd.ins_prio  = v.prio;
            cmd.ins_rank  = RANK_W'(res.count - WL_W'(1));
          end else begin
            cmd.sdec_en = 1'b1;
            cmd.sdec_id = run6;
          end
        end
      end

      S_SCAN: begin
        // Wait for the token to clear the row, then pick the head unless the lock is held.
        cnt_next = cnt + WL_W'(1);
        if (cnt == ROW_LEN) begin
          state_next = S_FIN;
          if (lock_count == 8'd0 && res.found) begin
            running_task_next = 5'(res.id);
            sw_next           = (res.id != run6);
          end
        end
      end

      S_FIN: begin
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      lock_count   <= 8'd0;
      running_task <= 5'd0;
      wait_len     <= '0;
      walk_n       <= '0;
      walk_i       <= '0;
      walk_k       <= '0;
      cnt          <= '0;
      sw_q         <= 1'b0;
      done         <= 1'b0;
      slice_ticks  <= 16'd10;
    end else begin
      state        <= state_next;
      lock_count   <= lock_count_next;
      running_task <= running_task_next;
      wait_len     <= wait_len_next;
      walk_n       <= walk_n_next;
      walk_i       <= walk_i_next;
      walk_k       <= walk_k_next;
      cnt          <= cnt_next;
      sw_q         <= sw_next;
      done         <= (state == S_FIN);
      if (slice_ticks_we) begin
        slice_ticks <= slice_ticks_wdata;
      end
    end
  end

  // Latch the command on accept; load the result as the item finishes.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      kind_q  <= kind;
      tid_q   <= task_id;
      prio_q  <= task_priority;
      ticks_q <= delay_ticks;
    end
    if (state == S_FIN) begin
      switch_now <= sw_q;
      next_task  <= running_task;
      any_ready  <= |ready_bits;
      lock_depth <= lock_count;
    end
  end

  `PTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `PTS_ASSERT_NOW(a_next_is_running, done, next_task == running_task, "result task mismatch")
  `PTS_ASSERT_NOW(a_wait_len, 1'b1, wait_len <= ROW_LEN, "delay list longer than task count")
  `PTS_ASSERT_NEXT(a_done_pulse, done, !done, "done held for more than one cycle")

endmodule
